>>> design/bub_pkg.sv
`timescale 1ns / 1ps

package bub_pkg;

  // Storage depth and derived widths.
  localparam int DEPTH   = 16;
  localparam int COUNT_W = 5;
  localparam int VALUE_W = 32;

  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

  // Request kinds.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [VALUE_W-1:0] item_value;
  } in_req_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] item_count;
  } out_res_t;

  // Control that the top level broadcasts to every cell.
  typedef struct packed {
    logic cmp_en;   // latch the per-cell match of the held request
    logic rem_en;   // apply a remove: cells at or past the first match shift down
    logic ins_en;   // apply an insert: the cell at the count position loads the item
  } cell_ctrl_t;

endpackage

>>> design/bub_cell.sv
`timescale 1ns / 1ps

module bub_cell (
  input  logic                         clk,
  input  logic [bub_pkg::COUNT_W-1:0]  cell_idx,
  input  bub_pkg::cell_ctrl_t          ctrl,
  input  logic [bub_pkg::VALUE_W-1:0]  req_value,
  input  logic [bub_pkg::COUNT_W-1:0]  count,
  input  logic [bub_pkg::VALUE_W-1:0]  upper_entry,
  input  logic                         hit_below,
  output logic                         hit_here_or_below,
  output logic [bub_pkg::VALUE_W-1:0]  entry
);
  import bub_pkg::*;

  logic [VALUE_W-1:0] entry_r;
  logic [VALUE_W-1:0] entry_nxt;
  logic               hit_r;
  logic               hit_nxt;
  logic               live;

  assign live              = cell_idx < count;
  assign hit_here_or_below = hit_below | hit_r;
  assign entry             = entry_r;

  // Only live cells may report a match, so unwritten storage is never compared.
  always_comb begin
    hit_nxt = hit_r;
    if (ctrl.cmp_en) begin
      hit_nxt = live && (entry_r == req_value);
    end
  end

  // A remove shifts every cell from the first match upward down by one.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins_en && (cell_idx == count)) begin
      entry_nxt = req_value;
    end else if (ctrl.rem_en && hit_here_or_below) begin
      entry_nxt = upper_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    hit_r   <= hit_nxt;
  end

endmodule

>>> design/bounded_unordered_bag_unit.sv
`timescale 1ns / 1ps

// Bounded unordered bag: holds up to DEPTH signed 32-bit items packed in
// insertion order in a row of storage cells, one item per cell.
// A request (insert, remove or query) is presented on in_req and taken at a
// rising edge where start is high and busy is low. Each request yields exactly
// one result on out_res, valid for the single cycle in which out_strobe is high.
// The receiver cannot stall the result, so it must capture it in that cycle.
// After the accepting edge, every cell compares its entry against the held
// request in parallel and latches its match; then, in the update cycle, the
// first-match flag ripples along the cell row, the cells shift or load, and
// the count is updated; the registered result is then strobed on out_res.
// busy covers the compare and update cycles, so a new request can be taken at
// the edge that ends the strobe cycle but not earlier. The user must write the
// capacity register through cfg_we and cfg_wdata only while no request is in
// flight, which the block does not enforce; a value above DEPTH acts as DEPTH.
// Synchronous reset empties the bag, sets the capacity to sixteen and drops
// any request in flight; the entry storage itself is not cleared.
// Type code three is accepted and answered with ok low and the count unchanged.

module bounded_unordered_bag_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  bub_pkg::in_req_t             in_req,
  input  logic                         cfg_we,
  input  logic [bub_pkg::COUNT_W-1:0]  cfg_wdata,
  output logic                         out_strobe,
  output bub_pkg::out_res_t            out_res
);
  import bub_pkg::*;

  logic               accept;
  in_req_t            req_r;
  logic               cmp_vld_r;
  logic               upd_vld_r;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic [COUNT_W-1:0] capacity_r;
  logic [COUNT_W-1:0] eff_cap;
  logic               can_insert;
  logic               found;
  logic               ok_nxt;
  cell_ctrl_t         ctrl;
  out_res_t           res_r;
  logic               strobe_r;

  logic [DEPTH:0]               hit_chain;
  logic [DEPTH-1:0][VALUE_W-1:0] entries;

  assign accept = start && !busy;
  assign busy   = cmp_vld_r || upd_vld_r;

  // Capacity beyond the physical depth is clamped.
  assign eff_cap    = (capacity_r > DEPTH_CNT) ? DEPTH_CNT : capacity_r;
  assign can_insert = count_r < eff_cap;
  assign found      = hit_chain[DEPTH];

  always_comb begin
    ctrl.cmp_en = cmp_vld_r;
    ctrl.rem_en = upd_vld_r && (req_r.req_type == REQ_REMOVE);
    ctrl.ins_en = upd_vld_r && (req_r.req_type == REQ_INSERT) && can_insert;
  end

  // Count and success flag for the request in its update cycle.
  always_comb begin
    count_nxt = count_r;
    ok_nxt    = 1'b0;
    unique case (req_r.req_type)
      REQ_INSERT: begin
        ok_nxt = can_insert;
        if (can_insert) begin
          count_nxt = count_r + COUNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        ok_nxt = found;
        if (found) begin
          count_nxt = count_r - COUNT_W'(1);
        end
      end
      REQ_QUERY: begin
        ok_nxt = found;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // The first-match flag enters the row at cell zero and moves upward.
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] upper;
    if (i == DEPTH - 1) begin : g_last
      assign upper = entries[i];
    end else begin : g_mid
      assign upper = entries[i+1];
    end

    bub_cell u_cell (
      .clk               (clk),
      .cell_idx          (COUNT_W'(i)),
      .ctrl              (ctrl),
      .req_value         (req_r.item_value),
      .count             (count_r),
      .upper_entry       (upper),
      .hit_below         (hit_chain[i]),
      .hit_here_or_below (hit_chain[i+1]),
      .entry             (entries[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r  <= 1'b0;
      upd_vld_r  <= 1'b0;
      strobe_r   <= 1'b0;
      count_r    <= '0;
      capacity_r <= COUNT_W'(16);
    end else begin
      cmp_vld_r <= accept;
      upd_vld_r <= cmp_vld_r;
      strobe_r  <= upd_vld_r;
      if (upd_vld_r) begin
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (upd_vld_r) begin
      res_r.ok         <= ok_nxt;
      res_r.item_count <= count_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("stored count exceeds depth");

  a_cmp_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |=> (upd_vld_r && !cmp_vld_r))
    else $error("compare cycle not followed by update cycle");

  a_upd_then_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    upd_vld_r |=> (out_strobe && !busy))
    else $error("update cycle not followed by result strobe");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_res.ok |-> out_res.item_count == $past(count_r, 1))
    else $error("failed request changed the count");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bub_pkg::*;

  // The package names only the three real request kinds; code three must be
  // answered with ok low and the count untouched.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Cycles with neither a request taken nor a result seen before the run is
  // declared hung. A correct request waits only through the busy cycles plus a
  // short random run of idle cycles, and capacity writes pause only while the
  // block drains.
  localparam int QUIET_LIMIT = 500;
  localparam int MAX_REPORTS = 200;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_req_t            in_req;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;
  logic               out_strobe;
  out_res_t           out_res;

  bounded_unordered_bag_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the bag: the stored items in insertion order, how many are
  // valid, and the capacity as last written.
  logic [VALUE_W-1:0] shadow_slots [DEPTH];
  int                 shadow_count;
  logic [COUNT_W-1:0] shadow_capacity;

  // Answers owed by the block, oldest first.
  out_res_t bag_answers [$];

  int error_count;
  int report_count;
  int idle_pct;
  int quiet_cycles;

  // Position of the first valid copy of the item, or -1 when it is absent.
  // Only positions below the count are looked at.
  function automatic int first_copy(input logic [VALUE_W-1:0] value);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_slots[i] == value) return i;
    end
    return -1;
  endfunction

  // Applies one request to the shadow bag and returns the answer the block
  // must give for it.
  function automatic out_res_t predict_bag_answer(input in_req_t req);
    out_res_t answer;
    int       limit;
    int       pos;
    // A capacity above the depth acts as the depth.
    limit = (int'(shadow_capacity) > DEPTH) ? DEPTH : int'(shadow_capacity);
    answer.ok = 1'b0;
    case (req.req_type)
      REQ_INSERT: begin
        if (shadow_count < limit) begin
          shadow_slots[shadow_count] = req.item_value;
          shadow_count++;
          answer.ok = 1'b1;
        end
      end
      REQ_REMOVE: begin
        pos = first_copy(req.item_value);
        if (pos >= 0) begin
          // Later entries close the hole so the bag stays dense.
          for (int j = pos + 1; j < shadow_count; j++) shadow_slots[j-1] = shadow_slots[j];
          shadow_count--;
          answer.ok = 1'b1;
        end
      end
      REQ_QUERY: begin
        answer.ok = (first_copy(req.item_value) >= 0);
      end
      default: begin
      end
    endcase
    answer.item_count = COUNT_W'(shadow_count);
    return answer;
  endfunction

  // Presents one request and waits until the block takes it. Inputs move on
  // the falling edge, where busy already shows whether the next rising edge
  // can take a request. Once the block is free, each cycle is left idle with
  // start low at the drawn rate; start stays high from one request to the
  // next unless an idle cycle is drawn.
  task automatic send_request(input logic [1:0] kind, input logic [VALUE_W-1:0] value);
    in_req_t req;
    req.req_type   = kind;
    req.item_value = value;
    @(negedge clk);
    while (busy) @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start  = 1'b1;
    in_req = req;
    @(posedge clk);
    bag_answers.push_back(predict_bag_answer(req));
  endtask

  // Stops offering requests, lets every owed answer come back and then idles
  // on, so that the block is surely quiet.
  task automatic drain_requests();
    @(negedge clk);
    start = 1'b0;
    while (bag_answers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Capacity writes happen only with the block idle.
  task automatic write_capacity(input logic [COUNT_W-1:0] value);
    drain_requests();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    shadow_capacity = value;
  endtask

  // Item for a remove or a query: mostly something that is stored, so that
  // hits and shifts from every position happen; otherwise an extreme, a small
  // number likely to collide, or any 32-bit pattern.
  function automatic logic [VALUE_W-1:0] pick_value();
    int                 roll;
    logic [VALUE_W-1:0] value;
    roll = $urandom_range(99);
    if (shadow_count != 0 && roll < 55) begin
      value = shadow_slots[$urandom_range(shadow_count - 1)];
    end else if (roll < 80) begin
      case ($urandom_range(5))
        0:       value = 32'h8000_0000;
        1:       value = 32'h7FFF_FFFF;
        2:       value = 32'h0000_0000;
        3:       value = 32'hFFFF_FFFF;
        default: value = VALUE_W'($urandom_range(7));
      endcase
    end else begin
      value = $urandom();
    end
    return value;
  endfunction

  // Inserting the most negative and most positive items, zero and minus one,
  // then looking for a stored and an absent item.
  task automatic test_extreme_items();
    send_request(REQ_INSERT, 32'h8000_0000);
    send_request(REQ_INSERT, 32'h7FFF_FFFF);
    send_request(REQ_INSERT, 32'h0000_0000);
    send_request(REQ_INSERT, 32'hFFFF_FFFF);
    send_request(REQ_QUERY, 32'h8000_0000);
    send_request(REQ_QUERY, 32'h1234_5678);
  endtask

  // A second copy is stored; a remove takes away only the first, so the item
  // is still found until the second remove.
  task automatic test_duplicates();
    send_request(REQ_INSERT, 32'h7FFF_FFFF);
    send_request(REQ_REMOVE, 32'h7FFF_FFFF);
    send_request(REQ_QUERY, 32'h7FFF_FFFF);
    send_request(REQ_REMOVE, 32'h7FFF_FFFF);
    send_request(REQ_QUERY, 32'h7FFF_FFFF);
    send_request(REQ_REMOVE, 32'h7FFF_FFFF);
  endtask

  task automatic test_unused_kind();
    send_request(REQ_UNUSED, 32'hFFFF_FFFF);
    send_request(REQ_UNUSED, 32'h0000_0000);
  endtask

  // The capacity drops below the count: stored items stay, and inserts fail
  // until removes bring the count under the new capacity.
  task automatic test_capacity_lowered();
    write_capacity(5'd2);
    send_request(REQ_INSERT, 32'h0000_0005);
    send_request(REQ_REMOVE, 32'h0000_0000);
    send_request(REQ_INSERT, 32'h0000_0005);
    send_request(REQ_REMOVE, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'h0000_0005);
  endtask

  // With a capacity of zero no insert succeeds, but removes and queries
  // still work on what is stored.
  task automatic test_capacity_zero();
    write_capacity(5'd0);
    send_request(REQ_INSERT, 32'h0000_0006);
    send_request(REQ_QUERY, 32'h0000_0005);
    send_request(REQ_REMOVE, 32'h0000_0005);
    send_request(REQ_REMOVE, 32'h8000_0000);
    send_request(REQ_QUERY, 32'h8000_0000);
  endtask

  // One phase of random traffic under a fixed capacity. The first half leans
  // toward inserts so the bag fills up to its limit, the second half toward
  // removes so it drains again; queries and the unused code are mixed in.
  task automatic run_random_phase(input logic [COUNT_W-1:0] capacity, input int count,
                                  input int gap_pct);
    int         roll;
    int         insert_pct;
    logic [1:0] kind;
    write_capacity(capacity);
    idle_pct = gap_pct;
    for (int n = 0; n < count; n++) begin
      insert_pct = (n < count / 2) ? 55 : 25;
      roll = $urandom_range(99);
      if (roll < insert_pct) kind = REQ_INSERT;
      else if (roll < 75) kind = REQ_REMOVE;
      else if (roll < 95) kind = REQ_QUERY;
      else kind = REQ_UNUSED;
      if (kind == REQ_INSERT && $urandom_range(3) == 0) send_request(kind, $urandom());
      else send_request(kind, pick_value());
    end
  endtask

  // Mixed traffic over several capacities: above the depth, exactly the
  // depth (with no idle gaps at all), one, just above the depth, a small
  // value, zero, a random value and a middling one.
  task automatic test_random_traffic();
    run_random_phase(5'd31, 260, 28);
    run_random_phase(5'd16, 260, 0);
    run_random_phase(5'd1, 200, 28);
    run_random_phase(5'd17, 260, 28);
    run_random_phase(5'd5, 220, 28);
    run_random_phase(5'd0, 60, 28);
    run_random_phase(COUNT_W'($urandom_range(31)), 220, 28);
    run_random_phase(5'd12, 220, 28);
  endtask

  // Every strobed result is matched against the oldest owed answer. The
  // block cannot be held off, so each strobe cycle is one result.
  always @(posedge clk) begin
    out_res_t want;
    if (rst_n && out_strobe) begin
      if (bag_answers.size() == 0) begin
        error_count++;
        if (report_count < MAX_REPORTS) begin
          report_count++;
          $display("%0t: result with none owed: expected nothing, got ok=%0b count=%0d",
                   $time, out_res.ok, out_res.item_count);
        end
      end else begin
        want = bag_answers.pop_front();
        if (out_res.ok !== want.ok) begin
          error_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("%0t: ok mismatch: expected %0b, got %0b", $time, want.ok, out_res.ok);
          end
        end
        if (out_res.item_count !== want.item_count) begin
          error_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("%0t: item_count mismatch: expected %0d, got %0d",
                     $time, want.item_count, out_res.item_count);
          end
        end
      end
    end
  end

  // Hang detection: any request taken or result strobed restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[bounded_unordered_bag_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_req       = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    error_count  = 0;
    report_count = 0;
    quiet_cycles = 0;
    idle_pct     = 28;
    // After reset the bag is empty and the capacity is the full depth.
    shadow_count    = 0;
    shadow_capacity = DEPTH_CNT;
    for (int i = 0; i < DEPTH; i++) shadow_slots[i] = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_extreme_items();
    test_duplicates();
    test_unused_kind();
    test_capacity_lowered();
    test_capacity_zero();
    test_random_traffic();

    drain_requests();
    if (error_count == 0) begin
      $display("[bounded_unordered_bag_unit] OK");
    end else begin
      $display("[bounded_unordered_bag_unit] ERROR");
    end
    $finish;
  end

endmodule
